/* src/reorder_buffer_with_branch_flush_top_macros.svh */
// Assertion macros for the reorder buffer checker
`ifndef REORDER_BUFFER_WITH_BRANCH_FLUSH_TOP_MACROS_SVH
`define REORDER_BUFFER_WITH_BRANCH_FLUSH_TOP_MACROS_SVH
`define ROB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rob check failed");
`define ROB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rob check failed");
`endif

/* src/rob_pkg.sv */
// Package: shared types and codes of the reorder buffer
`timescale 1ns / 1ps
`default_nettype none
package rob_pkg;
   typedef enum logic [2:0] {
      OP_ALLOC = 3'd0, OP_WVAL = 3'd1, OP_WBR = 3'd2, OP_WST = 3'd3, OP_COMMIT = 3'd4
   } op_type;
   typedef enum logic [1:0] {
      ST_DONE = 2'd0, ST_BUSY = 2'd1, ST_NOTFOUND = 2'd2
   } status_type;
   typedef enum logic [1:0] {
      S_IDLE, S_EXEC, S_OUT
   } state_type;
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;
endpackage
`default_nettype wire

/* src/reorder_buffer_with_branch_flush_top.sv */
// Top level of the reorder buffer with mispredict flush
// channel | prefix | direction | handshake
// request | req_   | in        | req_valid / req_stall
// result  | rsp_   | out       | rsp_valid / rsp_stall
// Each request passes through capture and execute before result hand-off;
// a new request is accepted only as the previous result is handed off, set by the
// single shared execute step over the entry file.
// Synchronous active-high reset empties the buffer.
// While a result is stalled the input is stalled as well; no request waits inside.
`timescale 1ns / 1ps
`default_nettype none
module reorder_buffer_with_branch_flush_top #(
   parameter int ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_op,
   input  wire logic [5:0]  req_instr_type,
   input  wire logic [4:0]  req_dest_reg,
   input  wire logic [31:0] req_pc,
   input  wire logic        req_is_branch,
   input  wire logic        req_pred_taken,
   input  wire logic        req_is_store,
   input  wire logic [31:0] req_pred_target,
   input  wire logic [15:0] req_tag,
   input  wire logic        req_taken,
   input  wire logic [31:0] req_value,
   input  wire logic [31:0] req_address,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_tag_out,
   output logic [31:0]      rsp_value_out,
   output logic             rsp_mispredict,
   output logic [5:0]       rsp_commit_type,
   output logic [4:0]       rsp_commit_dest_reg,
   output logic [31:0]      rsp_commit_pc,
   output logic             rsp_commit_is_store,
   output logic             rsp_commit_is_branch,
   output logic [31:0]      rsp_commit_target,
   output logic [31:0]      rsp_commit_store_addr,
   output logic [31:0]      rsp_commit_store_value
);
   import rob_pkg::*;
   cmd_type cmd;

   rob_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_stall, .rsp_valid, .cmd
   );

   rob_dp #(.ENTRIES(ENTRIES)) u_dp (
      .clock, .reset, .cmd,
      .req_op, .req_instr_type, .req_dest_reg, .req_pc, .req_is_branch,
      .req_pred_taken, .req_is_store, .req_pred_target, .req_tag, .req_taken,
      .req_value, .req_address,
      .rsp_status, .rsp_tag_out, .rsp_value_out, .rsp_mispredict, .rsp_commit_type,
      .rsp_commit_dest_reg, .rsp_commit_pc, .rsp_commit_is_store,
      .rsp_commit_is_branch, .rsp_commit_target, .rsp_commit_store_addr,
      .rsp_commit_store_value
   );
endmodule
`default_nettype wire

/* src/rob_ctrl.sv */
// Controller: sequences capture, execute and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module rob_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             rsp_stall,
   output logic                  rsp_valid,
   output rob_pkg::cmd_type      cmd
);
   import rob_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: state_in = S_OUT;
         S_OUT: begin
            if (!rsp_stall) state_in = req_valid ? S_EXEC : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.capture = req_valid;
         end
         S_EXEC: cmd.execute = 1'b1;
         S_OUT: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            cmd.capture = req_valid && !rsp_stall;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

/* src/rob_dp.sv */
// Datapath: entry storage, tag search, alloc/write/commit and result register
`timescale 1ns / 1ps
`default_nettype none
module rob_dp #(
   parameter int ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  rob_pkg::cmd_type cmd,
   input  wire logic [2:0]  req_op,
   input  wire logic [5:0]  req_instr_type,
   input  wire logic [4:0]  req_dest_reg,
   input  wire logic [31:0] req_pc,
   input  wire logic        req_is_branch,
   input  wire logic        req_pred_taken,
   input  wire logic        req_is_store,
   input  wire logic [31:0] req_pred_target,
   input  wire logic [15:0] req_tag,
   input  wire logic        req_taken,
   input  wire logic [31:0] req_value,
   input  wire logic [31:0] req_address,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_tag_out,
   output logic [31:0]      rsp_value_out,
   output logic             rsp_mispredict,
   output logic [5:0]       rsp_commit_type,
   output logic [4:0]       rsp_commit_dest_reg,
   output logic [31:0]      rsp_commit_pc,
   output logic             rsp_commit_is_store,
   output logic             rsp_commit_is_branch,
   output logic [31:0]      rsp_commit_target,
   output logic [31:0]      rsp_commit_store_addr,
   output logic [31:0]      rsp_commit_store_value
);
   import rob_pkg::*;
   localparam int IW = $clog2(ENTRIES);

   // captured request
   logic [2:0]  op_ff;
   logic [5:0]  type_ff;
   logic [4:0]  dest_ff;
   logic [31:0] pc_ff, ptgt_ff, value_ff, addr_ff;
   logic        br_ff, pt_ff, st_ff, taken_ff;
   logic [15:0] tag_ff;

   // per-entry flags
   logic [ENTRIES-1:0] busy_ff, ready_ff, isbr_ff, pred_ff, act_ff, isst_ff;
   logic [5:0]  mtype_ff [ENTRIES];
   logic [4:0]  mdest_ff [ENTRIES];
   logic [15:0] mtag_ff [ENTRIES];
   logic [31:0] val_ff [ENTRIES];
   logic [31:0] epc_ff [ENTRIES];
   logic [31:0] tgt_ff [ENTRIES];
   logic [31:0] eptgt_ff [ENTRIES];
   logic [31:0] saddr_ff [ENTRIES];
   logic [31:0] sdata_ff [ENTRIES];
   logic [IW-1:0] head_ff, tail_ff;
   logic [15:0] tagc_ff;

   logic [IW-1:0] head_nx, hit_idx;
   logic          hit;
   logic          full, hrdy, mis, wr_ok;

   always_comb begin
      head_nx = (head_ff == IW'(ENTRIES - 1)) ? '0 : head_ff + 1'b1;
      hit = 1'b0;
      hit_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (busy_ff[i] && mtag_ff[i] == tag_ff) begin
            hit = 1'b1;
            hit_idx = IW'(i);
         end
      end
      full = (head_ff == tail_ff) && busy_ff[head_ff];
      hrdy = busy_ff[head_ff] && ready_ff[head_ff];
      mis = isbr_ff[head_ff] && ((act_ff[head_ff] != pred_ff[head_ff]) ||
            (act_ff[head_ff] && tgt_ff[head_ff] != eptgt_ff[head_ff]));
      wr_ok = hit && !(op_ff == OP_WBR && !isbr_ff[hit_idx])
                  && !(op_ff == OP_WST && !isst_ff[hit_idx]);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op;       type_ff <= req_instr_type; dest_ff <= req_dest_reg;
         pc_ff <= req_pc;       ptgt_ff <= req_pred_target; value_ff <= req_value;
         addr_ff <= req_address; br_ff <= req_is_branch;   pt_ff <= req_pred_taken;
         st_ff <= req_is_store; taken_ff <= req_taken;     tag_ff <= req_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0; ready_ff <= '0; isbr_ff <= '0;
         pred_ff <= '0; act_ff <= '0;  isst_ff <= '0;
         head_ff <= '0; tail_ff <= '0; tagc_ff <= '0;
      end else if (cmd.execute) begin
         case (op_ff) inside
            OP_ALLOC: if (!full) begin
               busy_ff[tail_ff] <= 1'b1;   ready_ff[tail_ff] <= 1'b0;
               isbr_ff[tail_ff] <= br_ff;  pred_ff[tail_ff] <= pt_ff;
               act_ff[tail_ff] <= 1'b0;    isst_ff[tail_ff] <= st_ff;
               tagc_ff <= tagc_ff + 1'b1;
               tail_ff <= (tail_ff == IW'(ENTRIES - 1)) ? '0 : tail_ff + 1'b1;
            end
            OP_WVAL, OP_WST: if (wr_ok) ready_ff[hit_idx] <= 1'b1;
            OP_WBR: if (wr_ok) begin
               ready_ff[hit_idx] <= 1'b1;
               act_ff[hit_idx] <= taken_ff;
            end
            OP_COMMIT: if (hrdy) begin
               if (mis) begin
                  busy_ff <= '0;
                  tail_ff <= head_nx;
               end else busy_ff[head_ff] <= 1'b0;
               head_ff <= head_nx;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (op_ff == OP_ALLOC && !full) begin
            mtype_ff[tail_ff] <= type_ff;  mdest_ff[tail_ff] <= dest_ff;
            mtag_ff[tail_ff] <= tagc_ff;   val_ff[tail_ff] <= '0;
            epc_ff[tail_ff] <= pc_ff;      tgt_ff[tail_ff] <= addr_ff;
            eptgt_ff[tail_ff] <= ptgt_ff;  saddr_ff[tail_ff] <= '0;
            sdata_ff[tail_ff] <= '0;
         end
         if (wr_ok) begin
            if (op_ff == OP_WVAL) val_ff[hit_idx] <= value_ff;
            if (op_ff == OP_WBR) tgt_ff[hit_idx] <= addr_ff;
            if (op_ff == OP_WST) begin
               saddr_ff[hit_idx] <= addr_ff;
               sdata_ff[hit_idx] <= value_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_status <= ST_DONE;       rsp_tag_out <= '0;         rsp_value_out <= '0;
         rsp_mispredict <= 1'b0;      rsp_commit_type <= '0;     rsp_commit_dest_reg <= '0;
         rsp_commit_pc <= '0;         rsp_commit_is_store <= 1'b0;
         rsp_commit_is_branch <= 1'b0; rsp_commit_target <= '0;
         rsp_commit_store_addr <= '0; rsp_commit_store_value <= '0;
         case (op_ff) inside
            OP_ALLOC: begin
               if (full) rsp_status <= ST_BUSY;
               else rsp_tag_out <= tagc_ff;
            end
            OP_WVAL, OP_WBR, OP_WST: if (!wr_ok) rsp_status <= ST_NOTFOUND;
            OP_COMMIT: begin
               if (!hrdy) rsp_status <= ST_BUSY;
               else begin
                  rsp_tag_out <= mtag_ff[head_ff];
                  rsp_value_out <= val_ff[head_ff];
                  rsp_mispredict <= mis;
                  rsp_commit_type <= mtype_ff[head_ff];
                  rsp_commit_dest_reg <= mdest_ff[head_ff];
                  rsp_commit_pc <= epc_ff[head_ff];
                  rsp_commit_is_store <= isst_ff[head_ff];
                  rsp_commit_is_branch <= isbr_ff[head_ff];
                  rsp_commit_target <= tgt_ff[head_ff];
                  rsp_commit_store_addr <= saddr_ff[head_ff];
                  rsp_commit_store_value <= sdata_ff[head_ff];
               end
            end
            default: rsp_status <= ST_NOTFOUND;
         endcase
      end
   end
endmodule
`default_nettype wire

/* src/rob_checker.sv */
// Port-level checker for the reorder buffer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "reorder_buffer_with_branch_flush_top_macros.svh"
module rob_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_tag_out,
   input wire logic        rsp_mispredict,
   input wire logic        rsp_commit_is_branch
);
   import rob_pkg::*;
   logic rsp_hold, rsp_mis, mis_ok, rsp_done;

   assign rsp_hold = rsp_valid && rsp_stall;
   assign rsp_mis = rsp_valid && rsp_mispredict;
   assign mis_ok = rsp_commit_is_branch && rsp_status == ST_DONE;
   assign rsp_done = rsp_valid && !rsp_stall && !req_valid;

   `ROB_ASSERT_NEXT(a_hold, clock, reset, rsp_hold, rsp_valid && $stable(rsp_tag_out))
   `ROB_ASSERT_IMPL(a_mis_br, clock, reset, rsp_mis, mis_ok)
   `ROB_ASSERT_IMPL(a_status, clock, reset, rsp_valid, rsp_status <= ST_NOTFOUND)
   `ROB_ASSERT_NEXT(a_one_out, clock, reset, rsp_done, !rsp_valid)
endmodule
bind reorder_buffer_with_branch_flush_top rob_checker u_rob_checker (.*);
`default_nettype wire

/* dv/tb_reorder_buffer_with_branch_flush_top.sv */
// Testbench for the reorder buffer: directed rows, then random requests checked by a predictor
`timescale 1ns / 1ps
module tb_reorder_buffer_with_branch_flush_top;
   import rob_pkg::*;

   localparam int N_ITEMS = 1950;
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [2:0]  op;
      logic [5:0]  itype;
      logic [4:0]  dest;
      logic [31:0] pc;
      logic        br, pt, st;
      logic [31:0] ptgt;
      logic [15:0] tag;
      logic        tk;
      logic [31:0] val, addr;
   } rob_req_type;

   typedef struct {
      status_type  status;
      logic [15:0] tag;
      logic [31:0] val;
      logic        mis;
      logic [5:0]  ctype;
      logic [4:0]  cdest;
      logic [31:0] cpc;
      logic        cst, cbr;
      logic [31:0] ctgt, csaddr, csdata;
   } rob_rsp_type;

   typedef struct {
      rob_req_type r;
      bit          typed;
      rob_rsp_type e;
   } dir_row_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [2:0] req_op;
   logic [5:0] req_instr_type;
   logic [4:0] req_dest_reg;
   logic [31:0] req_pc, req_pred_target, req_value, req_address;
   logic req_is_branch, req_pred_taken, req_is_store, req_taken;
   logic [15:0] req_tag;
   logic rsp_valid, rsp_stall;
   logic [1:0] rsp_status;
   logic [15:0] rsp_tag_out;
   logic [31:0] rsp_value_out, rsp_commit_pc, rsp_commit_target;
   logic [31:0] rsp_commit_store_addr, rsp_commit_store_value;
   logic rsp_mispredict, rsp_commit_is_store, rsp_commit_is_branch;
   logic [5:0] rsp_commit_type;
   logic [4:0] rsp_commit_dest_reg;

   reorder_buffer_with_branch_flush_top dut (.*);

   // predicted buffer contents
   logic        e_busy[16], e_rdy[16], e_br[16], e_pt[16], e_at[16], e_st[16];
   logic [5:0]  e_type[16];
   logic [4:0]  e_dest[16];
   logic [15:0] e_tag[16];
   logic [31:0] e_val[16], e_pc[16], e_tgt[16], e_ptgt[16], e_saddr[16], e_sdata[16];
   logic [3:0]  head, tail;
   logic [15:0] tag_seq;

   dir_row_type  dir_rows[$];
   rob_rsp_type  pending_rsp[$];
   rob_req_type  cur;
   int           n_sent, n_err, phase_idle_pct, phase_stall_pct;
   bit           hold, sending_done;

   function automatic rob_rsp_type rob_apply(rob_req_type r);
      rob_rsp_type o;
      int k;
      logic [3:0] i;
      o = '{status: ST_DONE, default: '0};
      if (r.op == OP_ALLOC) begin
         if (head == tail && e_busy[head]) begin
            o.status = ST_BUSY;
            return o;
         end
         e_busy[tail] = 1; e_rdy[tail] = 0; e_br[tail] = r.br; e_pt[tail] = r.pt;
         e_at[tail] = 0; e_st[tail] = r.st; e_type[tail] = r.itype; e_dest[tail] = r.dest;
         e_tag[tail] = tag_seq; e_val[tail] = 0; e_pc[tail] = r.pc; e_tgt[tail] = r.addr;
         e_ptgt[tail] = r.ptgt; e_saddr[tail] = 0; e_sdata[tail] = 0;
         o.tag = tag_seq;
         tag_seq++;
         tail++;
      end else if (r.op == OP_WVAL || r.op == OP_WBR || r.op == OP_WST) begin
         k = -1;
         for (int j = 15; j >= 0; j--)
            if (e_busy[j] && e_tag[j] == r.tag) k = j;
         if (k < 0 || (r.op == OP_WBR && !e_br[k]) || (r.op == OP_WST && !e_st[k])) begin
            o.status = ST_NOTFOUND;
            return o;
         end
         e_rdy[k] = 1;
         if (r.op == OP_WVAL) e_val[k] = r.val;
         else if (r.op == OP_WBR) begin
            e_at[k] = r.tk; e_tgt[k] = r.addr;
         end else begin
            e_saddr[k] = r.addr; e_sdata[k] = r.val;
         end
      end else if (r.op == OP_COMMIT) begin
         if (!e_busy[head] || !e_rdy[head]) begin
            o.status = ST_BUSY;
            return o;
         end
         o.mis = e_br[head] && ((e_at[head] != e_pt[head]) ||
                 (e_at[head] && e_tgt[head] != e_ptgt[head]));
         o.tag = e_tag[head]; o.val = e_val[head]; o.ctype = e_type[head];
         o.cdest = e_dest[head]; o.cpc = e_pc[head]; o.cst = e_st[head];
         o.cbr = e_br[head]; o.ctgt = e_tgt[head]; o.csaddr = e_saddr[head];
         o.csdata = e_sdata[head];
         if (o.mis) begin
            for (i = head + 1; i != tail; i++) e_busy[i] = 0;
            tail = head + 1;
         end
         e_busy[head] = 0;
         head++;
      end else
         o.status = ST_NOTFOUND;
      return o;
   endfunction

   function automatic rob_req_type rand_req();
      rob_req_type r;
      int roll, live[$], k;
      r.op = OP_ALLOC; r.itype = 6'($urandom); r.dest = 5'($urandom); r.pc = $urandom;
      r.br = 1'($urandom); r.pt = 1'($urandom); r.st = 1'($urandom); r.ptgt = $urandom;
      r.tag = 16'($urandom); r.tk = 1'($urandom); r.val = $urandom; r.addr = $urandom;
      if (r.br) r.st = 0;
      for (int j = 0; j < 16; j++) if (e_busy[j]) live.push_back(j);
      roll = $urandom_range(99);
      if (roll < 32) begin
         if ($urandom_range(3) == 0) r.addr = r.ptgt;
      end else if (roll < 67 && live.size() > 0) begin
         k = live[$urandom_range(live.size() - 1)];
         r.tag = e_tag[k];
         if ($urandom_range(6) == 0) r.op = 3'($urandom_range(1, 3));
         else if (e_br[k] && $urandom_range(2) != 0) begin
            r.op = OP_WBR;
            if ($urandom_range(9) < 7) r.tk = e_pt[k];
            if ($urandom_range(9) < 7) r.addr = e_ptgt[k];
         end else if (e_st[k]) r.op = OP_WST;
         else r.op = OP_WVAL;
      end else if (roll < 92) r.op = OP_COMMIT;
      else r.op = 3'($urandom);
      return r;
   endfunction

   function automatic void add_row(rob_req_type r, bit typed, status_type s, logic [15:0] t);
      dir_row_type d;
      d.r = r; d.typed = typed;
      d.e = '{status: s, default: '0};
      d.e.tag = t;
      dir_rows.push_back(d);
   endfunction

   function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         n_err++;
         if (n_err <= 10)
            $display("mismatch %s: expected %h, got %h at %0t", name, e, a, $realtime);
      end
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // directed requests
   initial begin
      rob_req_type r;
      r = '{default: '0};
      r.op = OP_COMMIT; add_row(r, 1, ST_BUSY, 0);
      r.op = OP_WVAL;   add_row(r, 1, ST_NOTFOUND, 0);
      for (int u = 5; u <= 7; u++) begin
         r.op = 3'(u); add_row(r, 1, ST_NOTFOUND, 0);
      end
      r = '{op: OP_ALLOC, itype: '1, dest: '1, pc: '1, br: 1, pt: 1, st: 0, ptgt: '1,
            tag: '1, tk: 1, val: '1, addr: '1};
      add_row(r, 1, ST_DONE, 0);
      r = '{op: OP_ALLOC, st: 1, default: '0};
      add_row(r, 1, ST_DONE, 1);
      for (int j = 2; j < 16; j++) begin
         r = '{op: OP_ALLOC, itype: 6'($urandom), dest: 5'($urandom), pc: $urandom,
               br: j[0], pt: j[1], st: ~j[0], ptgt: $urandom, tag: 16'($urandom), tk: 0,
               val: $urandom, addr: $urandom};
         add_row(r, 1, ST_DONE, 16'(j));
      end
      r.op = OP_ALLOC; add_row(r, 1, ST_BUSY, 0);
      r = '{op: OP_WBR, tag: 1, default: '0}; add_row(r, 1, ST_NOTFOUND, 0);
      r = '{op: OP_WST, tag: 0, default: '0}; add_row(r, 1, ST_NOTFOUND, 0);
      r = '{op: OP_WBR, tag: 0, tk: 1, addr: 0, default: '0}; add_row(r, 0, ST_DONE, 0);
      r = '{op: OP_COMMIT, default: '0}; add_row(r, 0, ST_DONE, 0);
      r = '{op: OP_WST, tag: 1, default: '0}; add_row(r, 1, ST_NOTFOUND, 0);
      r = '{op: OP_COMMIT, default: '0}; add_row(r, 1, ST_BUSY, 0);
   end

   always @(posedge clock) begin
      if (n_sent < 400) begin
         phase_idle_pct <= 0;  phase_stall_pct <= 0;
      end else if (n_sent < 900) begin
         phase_idle_pct <= 69; phase_stall_pct <= 0;
      end else if (n_sent < 1400) begin
         phase_idle_pct <= 0;  phase_stall_pct <= 69;
      end else begin
         phase_idle_pct <= 32; phase_stall_pct <= 32;
      end
   end

   // request driver and predictor
   always @(posedge clock) begin
      rob_rsp_type o;
      rob_req_type nx;
      bit took;
      if (reset) begin
         req_valid <= 0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            o = rob_apply(cur);
            if (n_sent < dir_rows.size() && dir_rows[n_sent].typed) o = dir_rows[n_sent].e;
            pending_rsp.push_back(o);
            n_sent++;
         end
         if (took || !req_valid) begin
            if (n_sent >= N_ITEMS) begin
               req_valid <= 0;
               sending_done <= 1;
            end else if (n_sent >= dir_rows.size() && !hold &&
                         $urandom_range(99) < phase_idle_pct) begin
               req_valid <= 0;
            end else begin
               nx = (n_sent < dir_rows.size()) ? dir_rows[n_sent].r : rand_req();
               cur <= nx;
               req_valid <= 1;
               req_op <= nx.op; req_instr_type <= nx.itype; req_dest_reg <= nx.dest;
               req_pc <= nx.pc; req_is_branch <= nx.br; req_pred_taken <= nx.pt;
               req_is_store <= nx.st; req_pred_target <= nx.ptgt; req_tag <= nx.tag;
               req_taken <= nx.tk; req_value <= nx.val; req_address <= nx.addr;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= hold || ($urandom_range(99) < phase_stall_pct);
   end

   // long receiver hold-off so the buffer backs up into the input
   initial begin
      hold = 0;
      wait (n_sent >= HOLD_AT);
      @(posedge clock);
      hold <= 1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold <= 0;
   end

   always @(posedge clock) begin
      rob_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            n_err++;
            if (n_err <= 10) $display("unexpected result at %0t", $realtime);
         end else begin
            e = pending_rsp.pop_front();
            check_field("status", e.status, rsp_status);
            check_field("tag_out", e.tag, rsp_tag_out);
            check_field("value_out", e.val, rsp_value_out);
            check_field("mispredict", e.mis, rsp_mispredict);
            check_field("commit_type", e.ctype, rsp_commit_type);
            check_field("commit_dest_reg", e.cdest, rsp_commit_dest_reg);
            check_field("commit_pc", e.cpc, rsp_commit_pc);
            check_field("commit_is_store", e.cst, rsp_commit_is_store);
            check_field("commit_is_branch", e.cbr, rsp_commit_is_branch);
            check_field("commit_target", e.ctgt, rsp_commit_target);
            check_field("commit_store_addr", e.csaddr, rsp_commit_store_addr);
            check_field("commit_store_value", e.csdata, rsp_commit_store_value);
         end
      end
   end

   initial begin
      #10ms;
      $display("status: fail");
      $finish;
   end

   initial begin
      n_sent = 0; n_err = 0; sending_done = 0;
      phase_idle_pct = 0; phase_stall_pct = 0;
      head = 0; tail = 0; tag_seq = 0;
      for (int j = 0; j < 16; j++) e_busy[j] = 0;
      cur = '{default: '0};
      reset = 1; req_valid = 0; rsp_stall = 0;
      {req_op, req_instr_type, req_dest_reg, req_pc, req_is_branch, req_pred_taken} = '0;
      {req_is_store, req_pred_target, req_tag, req_taken, req_value, req_address} = '0;
      repeat (5) @(posedge clock);
      reset <= 0;
      wait (sending_done);
      wait (pending_rsp.size() == 0);
      repeat (20) @(posedge clock);
      if (n_err == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

/* files.f */
+incdir+src
src/rob_pkg.sv
src/rob_ctrl.sv
src/rob_dp.sv
src/reorder_buffer_with_branch_flush_top.sv
src/rob_checker.sv
dv/tb_reorder_buffer_with_branch_flush_top.sv
